// ===== rtl/derate_min_select_slew_limiter_core_defines.svh =====
`ifndef DERATE_MIN_SELECT_SLEW_LIMITER_CORE_DEFINES_SVH
`define DERATE_MIN_SELECT_SLEW_LIMITER_CORE_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define DMSL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define DMSL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/dmsl_pkg.sv =====
package dmsl_pkg;

  localparam int unsigned CHANNELS = 4;
  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [6:0] RATIO_FULL = 7'd100;

  localparam logic [3:0]  RST_EN_MASK = 4'd15;
  localparam logic [15:0] RST_HOLD_MS = 16'd5000;
  localparam logic [6:0]  RST_SLEW    = 7'd5;
  localparam logic [6:0]  RST_FLOOR   = 7'd55;

  localparam int unsigned EN_DRV    = 0;
  localparam int unsigned EN_LED    = 1;
  localparam int unsigned EN_SUPPLY = 2;
  localparam int unsigned EN_LOSS   = 3;

  localparam int unsigned PADDR_W = 4;

  typedef enum logic [1:0] {
    REG_EN_MASK = 2'd0,
    REG_HOLD_MS = 2'd1,
    REG_SLEW    = 2'd2,
    REG_FLOOR   = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    RSN_NONE   = 3'd0,
    RSN_LED    = 3'd1,
    RSN_DRV    = 3'd2,
    RSN_LOSS   = 3'd3,
    RSN_SUPPLY = 3'd4
  } reason_e;

  typedef struct packed {
    logic [3:0]  en_mask;
    logic [15:0] hold_ms;
    logic [6:0]  slew;
    logic [6:0]  floor_ratio;
  } cfg_t;

  typedef struct packed {
    logic [1:0] channel;
    logic [7:0] elapsed_ms;
    logic [6:0] led_ratio;
    logic [6:0] drv_ratio;
    logic [6:0] loss_ratio;
    logic [6:0] sup_ratio;
  } item_t;

  typedef struct packed {
    logic [15:0] led_tmr;
    logic [15:0] drv_tmr;
    logic [6:0]  applied;
  } chan_st_t;

  typedef struct packed {
    logic [1:0] out_channel;
    logic [6:0] current_ratio;
    logic [6:0] target_ratio;
    logic [2:0] reason;
  } res_t;

endpackage

// ===== rtl/dmsl_in_if.sv =====
interface dmsl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] channel;
  logic [7:0] elapsed_ms;
  logic [6:0] led_temp_ratio;
  logic [6:0] driver_temp_ratio;
  logic [6:0] loss_ratio;
  logic [6:0] supply_ratio;

  modport source (
    output valid, channel, elapsed_ms, led_temp_ratio, driver_temp_ratio,
           loss_ratio, supply_ratio,
    input  ready
  );

  modport sink (
    input  valid, channel, elapsed_ms, led_temp_ratio, driver_temp_ratio,
           loss_ratio, supply_ratio,
    output ready
  );
endinterface

// ===== rtl/dmsl_out_if.sv =====
interface dmsl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_channel;
  logic [6:0] current_ratio;
  logic [6:0] target_ratio;
  logic [2:0] reason;

  modport source (
    output valid, out_channel, current_ratio, target_ratio, reason,
    input  ready
  );

  modport sink (
    input  valid, out_channel, current_ratio, target_ratio, reason,
    output ready
  );
endinterface

// ===== rtl/dmsl_cfg_regs.sv =====
module dmsl_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmsl_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output dmsl_pkg::cfg_t                cfg_o
);

  dmsl_pkg::cfg_t     cfg_q, cfg_d;
  dmsl_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = dmsl_pkg::reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        dmsl_pkg::REG_EN_MASK: cfg_d.en_mask     = pwdata[3:0];
        dmsl_pkg::REG_HOLD_MS: cfg_d.hold_ms     = pwdata[15:0];
        dmsl_pkg::REG_SLEW:    cfg_d.slew        = pwdata[6:0];
        dmsl_pkg::REG_FLOOR:   cfg_d.floor_ratio = pwdata[6:0];
        default:               cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.en_mask     <= dmsl_pkg::RST_EN_MASK;
      cfg_q.hold_ms     <= dmsl_pkg::RST_HOLD_MS;
      cfg_q.slew        <= dmsl_pkg::RST_SLEW;
      cfg_q.floor_ratio <= dmsl_pkg::RST_FLOOR;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      dmsl_pkg::REG_EN_MASK: prdata = {28'd0, cfg_q.en_mask};
      dmsl_pkg::REG_HOLD_MS: prdata = {16'd0, cfg_q.hold_ms};
      dmsl_pkg::REG_SLEW:    prdata = {25'd0, cfg_q.slew};
      dmsl_pkg::REG_FLOOR:   prdata = {25'd0, cfg_q.floor_ratio};
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/dmsl_chan_update.sv =====
module dmsl_chan_update (
  input  dmsl_pkg::cfg_t     cfg_i,
  input  dmsl_pkg::item_t    item_i,
  input  dmsl_pkg::chan_st_t st_i,
  output dmsl_pkg::chan_st_t st_o,
  output dmsl_pkg::res_t     res_o
);

  typedef struct packed {
    logic [15:0] tmr;
    logic [6:0]  ratio;
  } hold_t;

  function automatic hold_t hold_zero(input logic [15:0] tmr, input logic [6:0] ratio,
                                      input logic [7:0] elapsed, input logic [15:0] hold_ms);
    hold_t       r;
    logic [15:0] t;
    t       = (ratio == '0 && tmr == '0) ? hold_ms : tmr;
    r.ratio = (t != '0) ? 7'd0 : ratio;
    r.tmr   = (t > {8'd0, elapsed}) ? t - {8'd0, elapsed} : 16'd0;
    return r;
  endfunction

  logic [6:0] led, drv, loss, sup, target, cur, nxt;
  logic [2:0] why;
  logic [7:0] diff;
  hold_t      led_h, drv_h;
  logic       in_range;

  assign in_range = ({30'd0, item_i.channel} < dmsl_pkg::CHANNELS);

  always_comb begin
    led  = cfg_i.en_mask[dmsl_pkg::EN_LED]    ? item_i.led_ratio  : dmsl_pkg::RATIO_FULL;
    drv  = cfg_i.en_mask[dmsl_pkg::EN_DRV]    ? item_i.drv_ratio  : dmsl_pkg::RATIO_FULL;
    sup  = cfg_i.en_mask[dmsl_pkg::EN_SUPPLY] ? item_i.sup_ratio  : dmsl_pkg::RATIO_FULL;
    loss = cfg_i.en_mask[dmsl_pkg::EN_LOSS]   ? item_i.loss_ratio : dmsl_pkg::RATIO_FULL;
    if (item_i.channel == 2'd0 && drv < cfg_i.floor_ratio) begin
      drv = cfg_i.floor_ratio;
    end

    led_h = hold_zero(st_i.led_tmr, led, item_i.elapsed_ms, cfg_i.hold_ms);
    drv_h = hold_zero(st_i.drv_tmr, drv, item_i.elapsed_ms, cfg_i.hold_ms);

    target = dmsl_pkg::RATIO_FULL;
    why    = dmsl_pkg::RSN_NONE;
    if (led_h.ratio < target) begin
      target = led_h.ratio;
      why    = dmsl_pkg::RSN_LED;
    end
    if (drv_h.ratio < target) begin
      target = drv_h.ratio;
      why    = dmsl_pkg::RSN_DRV;
    end
    if (loss < target) begin
      target = loss;
      why    = dmsl_pkg::RSN_LOSS;
    end
    if (sup < target) begin
      if (sup != '0) begin
        target = sup;
      end
      why = dmsl_pkg::RSN_SUPPLY;
    end

    // slew-limited move toward the target
    cur = st_i.applied;
    nxt = cur;
    if (cur > target) begin
      diff = {1'b0, cur} - {1'b0, target};
      nxt  = (diff > {1'b0, cfg_i.slew}) ? cur - cfg_i.slew : target;
    end else begin
      diff = {1'b0, target} - {1'b0, cur};
      nxt  = (diff > {1'b0, cfg_i.slew}) ? cur + cfg_i.slew : target;
    end

    if (in_range) begin
      st_o.led_tmr        = led_h.tmr;
      st_o.drv_tmr        = drv_h.tmr;
      st_o.applied        = nxt;
      res_o.current_ratio = nxt;
      res_o.target_ratio  = target;
      res_o.reason        = why;
    end else begin
      st_o                = st_i;
      res_o.current_ratio = dmsl_pkg::RATIO_FULL;
      res_o.target_ratio  = dmsl_pkg::RATIO_FULL;
      res_o.reason        = dmsl_pkg::RSN_NONE;
    end
    res_o.out_channel = item_i.channel;
  end

endmodule

// ===== rtl/derate_min_select_slew_limiter_core.sv =====
// Derate minimum-select core with zero-hold and slew limiting.
// in_i carries one periodic update for one channel: elapsed milliseconds and
// four source ratios (LED temp, driver temp, loss, supply). out_o returns one
// transaction per update: channel, slew-limited current ratio, target ratio
// and the reason code of the winning source.
// The APB port holds enable mask, zero-hold time, slew step and the channel
// zero driver floor; write it only while no transaction is in flight.
// Path: an accepted update is held in the input register, then the channel
// update logic writes the per-channel state and the result register, from
// which the result is offered on out_o.
// Throughput: one update per cycle while out_o is ready, also back to back on
// one channel, since state is written at the same edge as the result register.
// Reset: configuration returns to its defaults, hold timers clear, applied
// ratios go to 100, both pipeline stages empty.
// Stall: while out_o is not taken the result holds; the input register still
// takes one more update, then in_i.ready drops until the output drains.
`include "derate_min_select_slew_limiter_core_defines.svh"

module derate_min_select_slew_limiter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dmsl_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  dmsl_in_if.sink                      in_i,
  dmsl_out_if.source                   out_o
);

  dmsl_pkg::cfg_t     cfg;
  dmsl_pkg::item_t    s1_item_q;
  logic               s1_valid_q;
  logic               out_valid_q;
  dmsl_pkg::res_t     out_res_q, res;
  dmsl_pkg::chan_st_t st_q [dmsl_pkg::CHANNELS];
  dmsl_pkg::chan_st_t st_rd, st_nxt;
  logic [dmsl_pkg::CH_IDX_W-1:0] ch_idx;
  logic               in_ready, adv, s1_in_range;

  dmsl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign adv      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || adv;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_item_q.channel    <= in_i.channel;
      s1_item_q.elapsed_ms <= in_i.elapsed_ms;
      s1_item_q.led_ratio  <= in_i.led_temp_ratio;
      s1_item_q.drv_ratio  <= in_i.driver_temp_ratio;
      s1_item_q.loss_ratio <= in_i.loss_ratio;
      s1_item_q.sup_ratio  <= in_i.supply_ratio;
    end
  end

  assign ch_idx      = s1_item_q.channel[dmsl_pkg::CH_IDX_W-1:0];
  assign s1_in_range = ({30'd0, s1_item_q.channel} < dmsl_pkg::CHANNELS);
  assign st_rd       = st_q[ch_idx];

  dmsl_chan_update u_upd (
    .cfg_i  (cfg),
    .item_i (s1_item_q),
    .st_i   (st_rd),
    .st_o   (st_nxt),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dmsl_pkg::CHANNELS; i++) begin
        st_q[i].led_tmr <= '0;
        st_q[i].drv_tmr <= '0;
        st_q[i].applied <= dmsl_pkg::RATIO_FULL;
      end
    end else if (adv && s1_in_range) begin
      st_q[ch_idx] <= st_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_channel   = out_res_q.out_channel;
  assign out_o.current_ratio = out_res_q.current_ratio;
  assign out_o.target_ratio  = out_res_q.target_ratio;
  assign out_o.reason        = out_res_q.reason;

  `DMSL_ASSERT(a_adv_loads_out, adv |=> out_valid_q, "advanced item missing at output")
  `DMSL_ASSERT(a_stall_cause, !in_ready |-> (s1_valid_q && out_valid_q && !out_o.ready), "input stalled without a full pipeline")
  `DMSL_ASSERT(a_ratio_range, out_valid_q |-> (out_res_q.current_ratio <= dmsl_pkg::RATIO_FULL && out_res_q.target_ratio <= dmsl_pkg::RATIO_FULL), "ratio above 100")
  `DMSL_ASSERT(a_none_full, (out_valid_q && out_res_q.reason == dmsl_pkg::RSN_NONE) |-> (out_res_q.target_ratio == dmsl_pkg::RATIO_FULL), "no reason but target below 100")
  `DMSL_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (!s1_valid_q && !out_valid_q), "pipeline not empty in reset")

endmodule
